FILE: rtl/bxds_pkg.sv
// Shared types and constants of the box average downscaler.
// Holds the effective configuration record, the tile command format and register indexes.
// No dependencies; every other file of the block but bxds_div imports this package.
package bxds_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_IN_WIDTH   = 3'd0;
  localparam logic [2:0] REG_IN_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_BLOCK_W    = 3'd2;
  localparam logic [2:0] REG_BLOCK_H    = 3'd3;
  localparam logic [2:0] REG_OUT_WIDTH  = 3'd4;
  localparam logic [2:0] REG_OUT_HEIGHT = 3'd5;

  // Largest tile side and largest output height.
  localparam logic [4:0]  MAX_BLOCK      = 5'd16;
  localparam logic [10:0] MAX_OUT_HEIGHT = 11'd1024;

  // Depth of the command queue between front and back end.
  localparam int QDEPTH = 4;

  // Configuration after clamping, plus the tile area.
  typedef struct packed {
    logic [11:0] iw;
    logic [11:0] ih;
    logic [4:0]  bw;
    logic [4:0]  bh;
    logic [10:0] ow;
    logic [10:0] oh;
    logic [8:0]  area;
  } cfg_t;

  // One finished tile row, handed from the front end to the back end.
  typedef struct packed {
    logic [11:0] row_sum;
    logic [11:0] ox;
    logic [9:0]  oy;
    logic        first_row;
    logic        last_row;
    logic        frame_last;
  } cmd_t;

endpackage

FILE: rtl/bxds_cfg.sv
// Configuration registers of the downscaler with their clamped, effective values.
// Depends on bxds_pkg; the tile area is registered from the clamped tile sides.
module bxds_cfg #(
  parameter int MAX_OUT_WIDTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [11:0]         cfg_data,
  output bxds_pkg::cfg_t      cfg
);
  import bxds_pkg::*;

  logic [11:0] in_width;
  logic [11:0] in_height;
  logic [4:0]  block_w;
  logic [4:0]  block_h;
  logic [10:0] out_width;
  logic [10:0] out_height;
  logic [8:0]  area;
  logic [4:0]  bw_eff;
  logic [4:0]  bh_eff;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_width   <= 12'd720;
      in_height  <= 12'd720;
      block_w    <= 5'd7;
      block_h    <= 5'd7;
      out_width  <= 11'd100;
      out_height <= 11'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_WIDTH:   in_width   <= cfg_data;
        REG_IN_HEIGHT:  in_height  <= cfg_data;
        REG_BLOCK_W:    block_w    <= cfg_data[4:0];
        REG_BLOCK_H:    block_h    <= cfg_data[4:0];
        REG_OUT_WIDTH:  out_width  <= cfg_data[10:0];
        REG_OUT_HEIGHT: out_height <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Zero sizes count as one; tile sides and output sizes saturate.
  always_comb begin
    bw_eff = (block_w == 5'd0) ? 5'd1 : ((block_w > MAX_BLOCK) ? MAX_BLOCK : block_w);
    bh_eff = (block_h == 5'd0) ? 5'd1 : ((block_h > MAX_BLOCK) ? MAX_BLOCK : block_h);
    cfg.iw = (in_width == 12'd0) ? 12'd1 : in_width;
    cfg.ih = (in_height == 12'd0) ? 12'd1 : in_height;
    cfg.bw = bw_eff;
    cfg.bh = bh_eff;
    if (out_width == 11'd0) begin
      cfg.ow = 11'd1;
    end else if (13'(out_width) > 13'(MAX_OUT_WIDTH)) begin
      cfg.ow = 11'(MAX_OUT_WIDTH);
    end else begin
      cfg.ow = out_width;
    end
    if (out_height == 11'd0) begin
      cfg.oh = 11'd1;
    end else if (out_height > MAX_OUT_HEIGHT) begin
      cfg.oh = MAX_OUT_HEIGHT;
    end else begin
      cfg.oh = out_height;
    end
    cfg.area = area;
  end

  // Tile area, used only by the back end at the end of a tile.
  always_ff @(posedge clk) begin
    if (rst) begin
      area <= 9'd49;
    end else begin
      area <= 9'(bw_eff) * 9'(bh_eff);
    end
  end

endmodule

FILE: rtl/bxds_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Standalone; expects dividend >> QW to be smaller than the divisor.
module bxds_div #(
  parameter int DW = 16,
  parameter int VW = 9,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [QW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CW = $clog2(QW + 1);

  logic [VW-1:0] rem;
  logic [QW-1:0] quo;
  logic [CW-1:0] cnt;
  logic [VW-1:0] dvs;
  logic [VW+1:0] trial;
  logic          borrow;

  // Trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    trial  = {1'b0, rem, quo[QW-1]} - (VW + 2)'(dvs);
    borrow = trial[VW+1];
  end

  // Iteration: the dividend bits shift out of quo while quotient bits shift in.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= VW'(dividend >> QW);
        quo <= dividend[QW-1:0];
        dvs <= divisor;
        cnt <= CW'(QW);
      end else if (cnt != '0) begin
        rem  <= borrow ? {rem[VW-2:0], quo[QW-1]} : trial[VW-1:0];
        quo  <= {quo[QW-2:0], ~borrow};
        cnt  <= cnt - CW'(1);
        done <= (cnt == CW'(1));
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

FILE: rtl/bxds_front.sv
// Front end: accepts pixels, tracks the raster position and tile phases, sums tile rows.
// Depends on bxds_pkg and bxds_div; pushes one command per finished tile row inside the output size.
module bxds_front (
  input  logic           clk,
  input  logic           rst,
  input  bxds_pkg::cfg_t cfg,
  input  logic           cfg_we,
  input  logic           pix_valid,
  output logic           pix_ready,
  input  logic [7:0]     pixel,
  input  logic           q_full,
  output logic           q_push,
  output bxds_pkg::cmd_t q_cmd
);
  import bxds_pkg::*;

  typedef enum logic [1:0] {
    RUN,
    START,
    WAIT
  } state_t;

  state_t      state;
  logic [11:0] in_col;
  logic [11:0] in_row;
  logic [11:0] ox;
  logic [11:0] oy;
  logic [4:0]  x_phase;
  logic [4:0]  y_phase;
  logic [11:0] row_partial;

  logic [11:0] col_e;
  logic [11:0] row_e;
  logic [12:0] col_inc;
  logic [12:0] row_inc;
  logic [12:0] psum;
  logic [11:0] row_partial_next;
  logic        accept;
  logic        active;
  logic        div_start;
  logic        col_done;
  logic        row_done;
  logic [11:0] col_quo;
  logic [11:0] row_quo;
  logic [4:0]  col_rem;
  logic [4:0]  row_rem;

  // A position left beyond a lowered size restarts at zero.
  always_comb begin
    col_e   = (in_col >= cfg.iw) ? 12'd0 : in_col;
    row_e   = (in_row >= cfg.ih) ? 12'd0 : in_row;
    col_inc = 13'(col_e) + 13'd1;
    row_inc = 13'(row_e) + 13'd1;
  end

  // Classification of the current pixel and its running tile-row sum.
  always_comb begin
    accept = pix_valid && pix_ready;
    active = (ox < {1'b0, cfg.ow}) && (oy < {1'b0, cfg.oh});
    psum   = 13'(row_partial) + 13'(pixel);
    if (x_phase == 5'd0) begin
      row_partial_next = 12'(pixel);
    end else begin
      row_partial_next = psum[12] ? 12'hFFF : psum[11:0];
    end
    q_push             = accept && active && (x_phase == cfg.bw - 5'd1);
    q_cmd.row_sum      = row_partial_next;
    q_cmd.ox           = ox;
    q_cmd.oy           = oy[9:0];
    q_cmd.first_row    = (y_phase == 5'd0);
    q_cmd.last_row     = (y_phase == cfg.bh - 5'd1);
    q_cmd.frame_last   = (ox == 12'(cfg.ow - 11'd1)) && (oy == 12'(cfg.oh - 11'd1));
    pix_ready          = (state == RUN) && !q_full;
    div_start          = (state == START);
  end

  // Tile coordinates and phases are rebuilt from the position after a register write.
  bxds_div #(.DW(12), .VW(5), .QW(12)) u_col_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (col_e),
    .divisor   (cfg.bw),
    .done      (col_done),
    .quotient  (col_quo),
    .remainder (col_rem)
  );

  bxds_div #(.DW(12), .VW(5), .QW(12)) u_row_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (row_e),
    .divisor   (cfg.bh),
    .done      (row_done),
    .quotient  (row_quo),
    .remainder (row_rem)
  );

  // Position tracking and the recompute sequence; a register write restarts it.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= RUN;
      in_col      <= '0;
      in_row      <= '0;
      ox          <= '0;
      oy          <= '0;
      x_phase     <= '0;
      y_phase     <= '0;
      row_partial <= '0;
    end else begin
      unique case (state)
        RUN: begin
          if (accept) begin
            if (active) begin
              row_partial <= row_partial_next;
            end
            if (col_inc >= 13'(cfg.iw)) begin
              in_col  <= '0;
              ox      <= '0;
              x_phase <= '0;
              if (row_inc >= 13'(cfg.ih)) begin
                in_row  <= '0;
                oy      <= '0;
                y_phase <= '0;
              end else begin
                in_row <= row_inc[11:0];
                if (y_phase + 5'd1 == cfg.bh) begin
                  y_phase <= '0;
                  oy      <= oy + 12'd1;
                end else begin
                  y_phase <= y_phase + 5'd1;
                end
              end
            end else begin
              in_col <= col_inc[11:0];
              if (in_row >= cfg.ih) begin
                in_row <= '0;
              end
              if (x_phase + 5'd1 == cfg.bw) begin
                x_phase <= '0;
                ox      <= ox + 12'd1;
              end else begin
                x_phase <= x_phase + 5'd1;
              end
            end
          end
          if (cfg_we) begin
            state <= START;
          end
        end
        START: begin
          state <= cfg_we ? START : WAIT;
        end
        WAIT: begin
          if (cfg_we) begin
            state <= START;
          end else if (col_done && row_done) begin
            ox      <= col_quo;
            x_phase <= col_rem;
            oy      <= row_quo;
            y_phase <= row_rem;
            state   <= RUN;
          end
        end
        default: state <= RUN;
      endcase
    end
  end

endmodule

FILE: rtl/bxds_fifo.sv
// Short command queue between the front end and the back end.
// Depends on bxds_pkg for the command format and depth.
module bxds_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bxds_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output bxds_pkg::cmd_t head
);
  import bxds_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  cmd_t          entries [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full  = (count == (PW + 1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Storage; a full queue never sees a push.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW + 1)'(1);
      end
    end
  end

endmodule

FILE: rtl/bxds_back.sv
// Back end: sums tile rows per column and divides each finished tile by its area, capped at 255.
// Depends on bxds_pkg and bxds_div; holds the column sum memory and the output register.
module bxds_back #(
  parameter int MAX_OUT_WIDTH = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  bxds_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  bxds_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_average,
  output logic [9:0]     out_x,
  output logic [9:0]     out_y,
  output logic           out_last
);
  import bxds_pkg::*;

  localparam int AW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

  typedef enum logic [2:0] {
    IDLE,
    ACC,
    CHK,
    DIV,
    EMIT
  } state_t;

  state_t      state;
  cmd_t        cur;
  logic [15:0] tile_sum;
  logic [7:0]  avg;

  logic [15:0] col_mem [MAX_OUT_WIDTH];
  logic [15:0] rd_data;
  logic [16:0] acc_sum;
  logic [15:0] col_sum_next;
  logic        mem_we;
  logic        div_start;
  logic        saturated;
  logic        div_done;
  logic [7:0]  div_quo;
  logic [8:0]  div_rem;

  // Column sum update and the check for a mean above the pixel range.
  always_comb begin
    q_pop        = (state == IDLE) && !q_empty;
    acc_sum      = 17'(rd_data) + 17'(cur.row_sum);
    if (cur.first_row) begin
      col_sum_next = 16'(cur.row_sum);
    end else begin
      col_sum_next = acc_sum[16] ? 16'hFFFF : acc_sum[15:0];
    end
    mem_we    = (state == ACC);
    saturated = 17'(tile_sum) >= {cfg.area, 8'd0};
    div_start = (state == CHK) && !saturated;
  end

  // Column sums: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      col_mem[cur.ox[AW-1:0]] <= col_sum_next;
    end
    if (q_pop) begin
      rd_data <= col_mem[q_head.ox[AW-1:0]];
    end
  end

  bxds_div #(.DW(16), .VW(9), .QW(8)) u_avg_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (tile_sum),
    .divisor   (cfg.area),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Command sequencing and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (q_pop) begin
            cur   <= q_head;
            state <= ACC;
          end
        end
        ACC: begin
          tile_sum <= col_sum_next;
          state    <= cur.last_row ? CHK : IDLE;
        end
        CHK: begin
          if (saturated) begin
            avg   <= 8'hFF;
            state <= EMIT;
          end else begin
            state <= DIV;
          end
        end
        DIV: begin
          if (div_done && (div_rem <= cfg.area)) begin
            avg   <= div_quo;
            state <= EMIT;
          end
        end
        EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            out_average <= avg;
            out_x       <= cur.ox[9:0];
            out_y       <= cur.oy;
            out_last    <= cur.frame_last;
            state       <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/box_average_downscaler_top.sv
// Box average downscaler: 8-bit pixels in raster order, one mean per full tile in the output area.
// Throughput: one pixel per cycle while the 4-entry command queue has room and no rebuild runs;
// the back end takes one tile row at a time through IDLE and ACC, and a finished tile then through
// CHK, DIV and EMIT; DIV is left out when the mean saturates.
// A register write stalls the input while the dividers rebuild positions.
// Reset (rst, synchronous) restores the default registers and the frame start; sums need no clear.
module box_average_downscaler_top #(
  parameter int MAX_OUT_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // Pixel input.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  // Tile means.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] average, [17:8] out_x, [27:18] out_y, rest zero
  output logic        m_axis_tlast,   // frame_last
  // Configuration writes.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import bxds_pkg::*;

  cfg_t       cfg;
  cmd_t       push_cmd;
  cmd_t       head;
  logic       push;
  logic       full;
  logic       pop;
  logic       empty;
  logic [7:0] average;
  logic [9:0] out_x;
  logic [9:0] out_y;

  bxds_cfg #(.MAX_OUT_WIDTH(MAX_OUT_WIDTH)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bxds_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_we    (cfg_we),
    .pix_valid (s_axis_tvalid),
    .pix_ready (s_axis_tready),
    .pixel     (s_axis_tdata),
    .q_full    (full),
    .q_push    (push),
    .q_cmd     (push_cmd)
  );

  bxds_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  bxds_back #(.MAX_OUT_WIDTH(MAX_OUT_WIDTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (empty),
    .q_head      (head),
    .q_pop       (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_average (average),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_last    (m_axis_tlast)
  );

  // Output packing, first field in the lowest bits.
  assign m_axis_tdata = {4'd0, out_y, out_x, average};

endmodule

FILE: tb/tb_box_average_downscaler_top.sv
// Self-checking testbench for the box average downscaler.
// Streams pixels under several size settings and checks every tile mean against its own predictor.
// Depends on rtl/bxds_pkg.sv and rtl/box_average_downscaler_top.sv.
module tb_box_average_downscaler_top;
  import bxds_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_REPORTS    = 10;

  // One tile mean as it leaves the block.
  typedef struct packed {
    logic [7:0] average;
    logic [9:0] out_x;
    logic [9:0] out_y;
    logic       frame_last;
  } tile_mean_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;     // [7:0] pixel
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // [7:0] average, [17:8] out_x, [27:18] out_y
  logic        m_axis_tlast;          // frame_last
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_IN_WIDTH;
  logic [11:0] cfg_data = '0;

  // Traffic shaping, changed only while the block is idle.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_start = 1'b0;
  int unsigned hold_left  = 0;

  logic [7:0]  pixels_pending[$];
  tile_mean_t  means_due[$];
  int unsigned pixels_queued = 0;
  int unsigned pixels_taken  = 0;
  int unsigned means_seen    = 0;
  int unsigned err_count     = 0;
  int unsigned phase_no      = 0;

  // Shadow copy of the size registers, reset values first.
  logic [11:0] reg_in_width   = 12'd720;
  logic [11:0] reg_in_height  = 12'd720;
  logic [4:0]  reg_block_w    = 5'd7;
  logic [4:0]  reg_block_h    = 5'd7;
  logic [10:0] reg_out_width  = 11'd100;
  logic [10:0] reg_out_height = 11'd100;

  // Predictor state: per-column tile sums, running tile-row sum, next pixel position.
  int unsigned tile_col_sum[1024];
  int unsigned strip_sum = 0;
  int unsigned next_col  = 0;
  int unsigned next_row  = 0;

  box_average_downscaler_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Zero sizes count as one, oversized ones saturate.
  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Advance the predictor by one accepted pixel and queue the mean it completes, if any.
  task automatic predict_pixel(input logic [7:0] px);
    int unsigned iw, ih, bw, bh, ow, oh, ox, oy, xp, yp, s, avg, pv;
    tile_mean_t m;
    pv = 32'(px);
    iw = clamp_size(32'(reg_in_width), 4095);
    ih = clamp_size(32'(reg_in_height), 4095);
    bw = clamp_size(32'(reg_block_w), 16);
    bh = clamp_size(32'(reg_block_h), 16);
    ow = clamp_size(32'(reg_out_width), 1024);
    oh = clamp_size(32'(reg_out_height), 1024);
    if (next_col >= iw) next_col = 0;
    if (next_row >= ih) next_row = 0;
    ox = next_col / bw;
    oy = next_row / bh;
    xp = next_col % bw;
    yp = next_row % bh;
    if (ox < ow && oy < oh) begin
      if (xp == 0) strip_sum = pv;
      else strip_sum = (strip_sum + pv > 4095) ? 4095 : strip_sum + pv;
      if (xp == bw - 1) begin
        s = (yp == 0) ? strip_sum : tile_col_sum[ox] + strip_sum;
        if (s > 65535) s = 65535;
        tile_col_sum[ox] = s;
        if (yp == bh - 1) begin
          avg = s / (bw * bh);
          if (avg > 255) avg = 255;
          m.average    = 8'(avg);
          m.out_x      = 10'(ox);
          m.out_y      = 10'(oy);
          m.frame_last = (ox == ow - 1 && oy == oh - 1);
          means_due.push_back(m);
        end
      end
    end
    next_col++;
    if (next_col >= iw) begin
      next_col = 0;
      next_row++;
      if (next_row >= ih) next_row = 0;
    end
  endtask

  // Pixel driver: a new transaction, or a random idle, whenever the previous one has gone through.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pixels_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pixels_pending.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted down on its own.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result receiver with random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Input monitor feeds the predictor with every accepted pixel.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      predict_pixel(s_axis_tdata);
      pixels_taken++;
    end
  end

  // Output monitor compares each tile mean with the oldest prediction.
  always @(posedge clk) begin
    tile_mean_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.average    = m_axis_tdata[7:0];
      got.out_x      = m_axis_tdata[17:8];
      got.out_y      = m_axis_tdata[27:18];
      got.frame_last = m_axis_tlast;
      means_seen++;
      if (means_due.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("Unexpected tile mean: avg %0d at (%0d,%0d) last %0d",
                   got.average, got.out_x, got.out_y, got.frame_last);
      end else begin
        want = means_due.pop_front();
        if (got != want || m_axis_tdata[31:28] != '0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display({"Tile mean mismatch: expected avg %0d at (%0d,%0d) last %0d, ",
                      "got avg %0d at (%0d,%0d) last %0d pad %0h"},
                     want.average, want.out_x, want.out_y, want.frame_last,
                     got.average, got.out_x, got.out_y, got.frame_last, m_axis_tdata[31:28]);
        end
      end
    end
  end

  // Register write; the shadow copy keeps only the register's own width.
  task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_IN_WIDTH:   reg_in_width   = val;
      REG_IN_HEIGHT:  reg_in_height  = val;
      REG_BLOCK_W:    reg_block_w    = val[4:0];
      REG_BLOCK_H:    reg_block_h    = val[4:0];
      REG_OUT_WIDTH:  reg_out_width  = val[10:0];
      REG_OUT_HEIGHT: reg_out_height = val[10:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_sizes(input logic [11:0] iw, ih, bw, bh, ow, oh);
    write_reg(REG_IN_WIDTH, iw);
    write_reg(REG_IN_HEIGHT, ih);
    write_reg(REG_BLOCK_W, bw);
    write_reg(REG_BLOCK_H, bh);
    write_reg(REG_OUT_WIDTH, ow);
    write_reg(REG_OUT_HEIGHT, oh);
    end_writes();
  endtask

  // Sometimes set bits above the register width; the block must ignore them.
  function automatic logic [11:0] with_junk(input int unsigned val, input int unsigned width);
    logic [11:0] junk;
    junk = 12'($urandom()) << width;
    return ($urandom_range(1) != 0) ? (12'(val) | junk) : 12'(val);
  endfunction

  task automatic push_pixel(input logic [7:0] px);
    pixels_pending.push_back(px);
    pixels_queued++;
  endtask

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic push_random(input int unsigned count);
    repeat (count) push_pixel(rand_pixel());
  endtask

  // Wait until every pixel went in and every mean came out, then let the pipeline settle.
  task automatic wait_drained();
    while (pixels_taken != pixels_queued || means_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Each phase gets the next traffic pattern in turn.
  task automatic begin_phase();
    case (phase_no % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
      default: begin send_idle_pct = 21; recv_stall_pct = 21; end
    endcase
    phase_no++;
  endtask

  // Random sizes, mostly small tiles, always whole frames so the position ends at the origin.
  task automatic random_phase(output int unsigned pushed);
    int unsigned bw, bh, ow, oh, iw, ih, frames;
    bw = ($urandom_range(3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
    bh = ($urandom_range(3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
    ow = $urandom_range(1, (bw > 4) ? 2 : 6);
    oh = $urandom_range(1, (bh > 4) ? 2 : 4);
    iw = ow * bw + $urandom_range(0, 3);
    ih = oh * bh + $urandom_range(0, 2);
    // Now and then ask for an extra output column; it is filled only if spare columns make a tile.
    if ($urandom_range(7) == 0) ow++;
    frames = (iw * ih > 200) ? 1 : $urandom_range(1, 2);
    begin_phase();
    set_sizes(12'(iw), 12'(ih), with_junk(bw, 5), with_junk(bh, 5),
              with_junk(ow, 11), with_junk(oh, 11));
    pushed = iw * ih * frames;
    push_random(pushed);
    wait_drained();
  endtask

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned pushed, rand_pixels;
    rand_pixels = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed: all sizes zero, so every pixel is its own tile.
    begin_phase();
    set_sizes(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    push_pixel(8'h00);
    push_pixel(8'hFF);
    wait_drained();

    // Directed: the second output column needs pixels past the line end and never completes.
    begin_phase();
    set_sizes(12'd4, 12'd2, 12'd3, 12'd2, 12'd2, 12'd1);
    push_random(8);
    wait_drained();

    // Directed: line width lowered below the current column in the middle of a line.
    begin_phase();
    set_sizes(12'd8, 12'd2, 12'd2, 12'd2, 12'd4, 12'd1);
    push_random(5);
    wait_drained();
    write_reg(REG_IN_WIDTH, 12'd4);
    write_reg(REG_OUT_WIDTH, 12'd2);
    end_writes();
    push_random(8);
    wait_drained();

    // Directed: frame height lowered below the current row.
    begin_phase();
    set_sizes(12'd1, 12'd6, 12'd1, 12'd2, 12'd1, 12'd3);
    push_random(3);
    wait_drained();
    write_reg(REG_IN_HEIGHT, 12'd2);
    write_reg(REG_OUT_HEIGHT, 12'd1);
    end_writes();
    push_random(2);
    wait_drained();

    // Back-pressure: the receiver holds off for a long stretch while pixels keep coming.
    begin_phase();
    send_idle_pct = 0;
    set_sizes(12'd6, 12'd5, 12'd1, 12'd1, 12'd6, 12'd5);
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    push_random(30);
    wait_drained();

    // Tile narrowed mid-line: the running row sum and the mean both saturate.
    begin_phase();
    set_sizes(12'd18, 12'd1, 12'd16, 12'd1, 12'd1, 12'd1);
    repeat (16) push_pixel(8'hFF);
    wait_drained();
    write_reg(REG_BLOCK_W, 12'd9);
    write_reg(REG_OUT_WIDTH, 12'd2);
    end_writes();
    repeat (2) push_pixel(8'($urandom_range(16, 255)));
    wait_drained();

    // Tile height changed mid-frame: the column sum saturates.
    begin_phase();
    set_sizes(12'd16, 12'd18, 12'd16, 12'd16, 12'd1, 12'd1);
    repeat (256) push_pixel(8'hFF);
    wait_drained();
    write_reg(REG_BLOCK_H, 12'd9);
    write_reg(REG_OUT_HEIGHT, 12'd2);
    end_writes();
    repeat (32) push_pixel(8'($urandom_range(16, 255)));
    wait_drained();

    // Oversized tile width and output width, zero tile height and output height.
    begin_phase();
    set_sizes(12'd16, 12'd1, 12'd31, 12'd0, 12'd2047, 12'd0);
    push_random(16);
    wait_drained();

    // Oversized tile height and output height, zero widths.
    begin_phase();
    set_sizes(12'd0, 12'd16, 12'd0, 12'd20, 12'd0, 12'd2047);
    push_random(16);
    wait_drained();

    // A few random sizes and contents to finish the run.
    while (rand_pixels < 50) begin
      random_phase(pushed);
      rand_pixels += pushed;
    end

    wait_drained();
    $display("Covered %0d phases with %0d pixels in and %0d tile means out.",
             phase_no, pixels_taken, means_seen);
    $display("Random part: %0d pixels; mismatches: %0d.", rand_pixels, err_count);
    if (err_count == 0 && means_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: box_average_downscaler_top.f
rtl/bxds_pkg.sv
rtl/bxds_cfg.sv
rtl/bxds_div.sv
rtl/bxds_front.sv
rtl/bxds_fifo.sv
rtl/bxds_back.sv
rtl/box_average_downscaler_top.sv
tb/tb_box_average_downscaler_top.sv
